// ----- hdl/wspr_pkg.sv -----
// ----------------------------------------------------------------------------
// wspr_pkg
// Shared types and constants of the WSPR type 1 message symbol encoder.
// ----------------------------------------------------------------------------
package wspr_pkg;

    localparam int unsigned NSYM = 162;
    localparam logic [7:0] SYM_LAST = 8'(NSYM - 1);

    localparam logic [31:0] POLY_A = 32'hF2D0_5351;
    localparam logic [31:0] POLY_B = 32'hE461_3C47;

    // command codes carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // standard sync vector, element 0 in the leftmost bit
    localparam logic [0:NSYM-1] SYNC_BITS = {
        32'b11000000_10001110_00100101_11100000,
        32'b00100101_00000010_11001101_00011010,
        32'b00011010_10101001_00101100_01101010,
        32'b00100000_10010011_10110011_01000111,
        32'b00000101_00110000_00011010_11000110,
        2'b00
    };

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic n_step;
        logic enc_step;
        logic emit;
    } wspr_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic call_last;
        logic enc_last;
        logic msg_ready;
        logic out_free;
    } wspr_sts_t;

endpackage

// ----- hdl/wspr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wspr_ctrl
// Controller: sequences message packing, encoding and tone reads.
// ----------------------------------------------------------------------------
module wspr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                cmd,
    input  wspr_pkg::wspr_sts_t sts,
    output wspr_pkg::wspr_ctl_t ctl
);
    import wspr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALL = 5'b00010,
        S_ENC  = 5'b00100,
        S_RD   = 5'b01000,
        S_WR   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctl.capture = 1'b1;
                        state_next  = S_CALL;
                    end
                    else if (sts.msg_ready)
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_CALL:
            begin
                ctl.n_step = 1'b1;
                if (sts.call_last)
                    state_next = S_ENC;
            end
            S_ENC:
            begin
                ctl.enc_step = 1'b1;
                if (sts.enc_last)
                    state_next = S_IDLE;
            end
            S_RD:
            begin
                // store read data lands this cycle
                state_next = S_WR;
            end
            S_WR:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hdl/wspr_dp.sv -----
// ----------------------------------------------------------------------------
// wspr_dp
// Datapath: callsign and locator packing, K=32 convolutional encoder,
// interleaved coded-bit store and tone output register.
// ----------------------------------------------------------------------------
module wspr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [79:0]         in_data,
    input  wspr_pkg::wspr_ctl_t ctl,
    output wspr_pkg::wspr_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          symbol_index,
    output logic [1:0]          tone,
    output logic                last_symbol
);
    import wspr_pkg::*;

    function automatic logic [5:0] char_full(input logic [6:0] c);
        logic [5:0] r;
        if (c >= 7'd48 && c <= 7'd57)
            r = 6'(c - 7'd48);
        else if (c >= 7'd65 && c <= 7'd90)
            r = 6'(c - 7'd55);
        else
            r = 6'd36;
        return r;
    endfunction

    function automatic logic [5:0] char_suffix(input logic [6:0] c);
        logic [5:0] r;
        if (c >= 7'd65 && c <= 7'd90)
            r = 6'(c - 7'd65);
        else
            r = 6'd26;
        return r;
    endfunction

    function automatic logic [6:0] clamp_sub(input logic [6:0] c, input logic [6:0] lo,
                                             input logic [6:0] hi);
        logic [6:0] r;
        if (c < lo)
            r = 7'd0;
        else if (c > hi)
            r = hi - lo;
        else
            r = c - lo;
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++)
            r[k] = v[7-k];
        return r;
    endfunction

    // captured callsign characters
    logic [6:0]  c0_reg, c1_reg, c3_reg, c4_reg, c5_reg;
    logic [5:0]  c2_reg;
    logic [21:0] m_reg;
    logic [27:0] n_reg;
    logic [2:0]  step_reg;
    logic [49:0] msg_reg;
    logic [31:0] shift_reg;
    logic [7:0]  g_reg;
    logic        phase_reg;
    logic [7:0]  next_sym_reg;
    logic        ready_reg;
    logic        rd_bit_reg;
    logic        out_valid_reg;
    logic [7:0]  out_idx_reg;
    logic [1:0]  out_tone_reg;
    logic        out_last_reg;

    logic        mem [NSYM];

    // locator and power word
    logic [4:0]  lon_l, lat_l;
    logic [3:0]  lon_d, lat_d;
    logic [7:0]  loc_hi;
    logic [14:0] loc;
    logic [21:0] m_word;

    always_comb
    begin
        lon_l  = 5'(clamp_sub(in_data[47:41], 7'd65, 7'd82));
        lat_l  = 5'(clamp_sub(in_data[54:48], 7'd65, 7'd82));
        lon_d  = 4'(clamp_sub({1'b0, in_data[60:55]}, 7'd48, 7'd57));
        lat_d  = 4'(clamp_sub({1'b0, in_data[66:61]}, 7'd48, 7'd57));
        loc_hi = 8'd179 - 8'(lon_l) * 8'd10 - 8'(lon_d);
        loc    = 15'(loc_hi) * 15'd180 + 15'(lat_l) * 15'd10 + 15'(lat_d);
        // power + 64 never carries out of the low seven bits
        m_word = {loc, 1'b1, in_data[72:67]};
    end

    // callsign packing, one character per step
    logic [5:0]  n_mult;
    logic [5:0]  n_val;
    logic [33:0] n_wide;
    logic [27:0] n_next;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                n_mult = 6'd36;
                n_val  = char_full(c0_reg);
            end
            3'd1:
            begin
                n_mult = 6'd36;
                n_val  = char_full(c1_reg);
            end
            3'd2:
            begin
                n_mult = 6'd10;
                n_val  = char_full({1'b0, c2_reg});
            end
            3'd3:
            begin
                n_mult = 6'd27;
                n_val  = char_suffix(c3_reg);
            end
            3'd4:
            begin
                n_mult = 6'd27;
                n_val  = char_suffix(c4_reg);
            end
            default:
            begin
                n_mult = 6'd27;
                n_val  = char_suffix(c5_reg);
            end
        endcase
        n_wide = 34'(n_reg) * 34'(n_mult) + 34'(n_val);
        n_next = n_wide[27:0];
    end

    // encoder and interleaver
    logic [7:0]  slot;
    logic        slot_ok;
    logic [31:0] sh;
    logic        we;
    logic        wbit;

    always_comb
    begin
        slot    = rev8(g_reg);
        slot_ok = (slot <= SYM_LAST);
        sh      = {shift_reg[30:0], msg_reg[49]};
        we      = ctl.enc_step && slot_ok;
        wbit    = phase_reg ? (^(shift_reg & POLY_B)) : (^(sh & POLY_A));
    end

    assign sts.call_last = (step_reg == 3'd5);
    assign sts.enc_last  = (g_reg == 8'hFF);
    assign sts.msg_ready = ready_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            c0_reg <= in_data[6:0];
            c1_reg <= in_data[13:7];
            c2_reg <= in_data[19:14];
            c3_reg <= in_data[26:20];
            c4_reg <= in_data[33:27];
            c5_reg <= in_data[40:34];
            m_reg  <= m_word;
            n_reg  <= '0;
        end
        else if (ctl.n_step)
        begin
            n_reg <= n_next;
            if (sts.call_last)
                msg_reg <= {n_next, m_reg};
        end
        else if (we && !phase_reg)
        begin
            // message bits leave msb first, zeros follow
            msg_reg <= {msg_reg[48:0], 1'b0};
        end
        if (ctl.emit)
        begin
            out_idx_reg  <= next_sym_reg;
            out_tone_reg <= {rd_bit_reg, SYNC_BITS[next_sym_reg]};
            out_last_reg <= (next_sym_reg == SYM_LAST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[slot] <= wbit;
        rd_bit_reg <= mem[next_sym_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            shift_reg     <= '0;
            g_reg         <= '0;
            phase_reg     <= 1'b0;
            next_sym_reg  <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                step_reg  <= '0;
                shift_reg <= '0;
                g_reg     <= '0;
                phase_reg <= 1'b0;
            end
            else if (ctl.n_step)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else if (ctl.enc_step)
            begin
                g_reg <= g_reg + 8'd1;
                if (slot_ok)
                begin
                    if (!phase_reg)
                        shift_reg <= sh;
                    phase_reg <= !phase_reg;
                end
                if (sts.enc_last)
                begin
                    next_sym_reg <= '0;
                    ready_reg    <= 1'b1;
                end
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
                next_sym_reg  <= (next_sym_reg == SYM_LAST) ? 8'd0 : next_sym_reg + 8'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_index = out_idx_reg;
    assign tone         = out_tone_reg;
    assign last_symbol  = out_last_reg;

    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_sym_reg <= SYM_LAST)
        else $error("tone index out of range");

    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> ready_reg && sts.out_free)
        else $error("tone emitted without message or over a pending transfer");

    a_enc_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enc_step && sts.enc_last |=> ready_reg && next_sym_reg == 8'd0 && !phase_reg)
        else $error("encoder did not finish cleanly");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.n_step |-> step_reg <= 3'd5)
        else $error("callsign step overrun");

endmodule

// ----- hdl/wspr_message_symbol_encoder.sv -----
// Load transfer: the next input transfer is taken only after the capture, 6 callsign
// packing steps and 256 interleaver address steps that follow acceptance.
// Tone request: after acceptance the store read and output write states load the output
// register; the next request is taken back in idle, later while m_tready is low.
// Reset clears control state; tone requests before the first load give no result.
// ----------------------------------------------------------------------------
// wspr_message_symbol_encoder
// WSPR type 1 message encoder: packs callsign, locator and power, runs the
// K=32 rate 1/2 convolutional code and returns one 4-level tone per request.
// ----------------------------------------------------------------------------
module wspr_message_symbol_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // call_char_0..5, loc_lon_letter, loc_lat_letter, loc_lon_digit,
    // loc_lat_digit, power_dbm, zero pad
    input  logic [79:0] s_tdata,
    // cmd
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol_index, tone, zero pad
    output logic [15:0] m_tdata,
    output logic        m_tlast
);
    import wspr_pkg::*;

    wspr_ctl_t  ctl;
    wspr_sts_t  sts;
    logic [7:0] symbol_index;
    logic [1:0] tone;

    wspr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tuser[0]),
        .sts      (sts),
        .ctl      (ctl)
    );

    wspr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (s_tdata),
        .ctl          (ctl),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .symbol_index (symbol_index),
        .tone         (tone),
        .last_symbol  (m_tlast)
    );

    assign m_tdata = {6'b0, tone, symbol_index};

endmodule
